// ----- hdl/nal_kf_pkg.sv -----
// ----------------------------------------------------------------------------
// NAL keyframe detector package
// Shared types, constants and the NAL header classification function.
// ----------------------------------------------------------------------------
package nal_kf_pkg;

  // Default widths for the top-level parameters.
  localparam int FRAME_INDEX_BITS_DEF = 24;
  localparam int STREAM_ID_BITS_DEF   = 4;

  // Configuration register indexes.
  localparam logic CFG_CODEC_MODE      = 1'b0;
  localparam logic CFG_SELECTED_STREAM = 1'b1;

  // Codec modes. The unused fourth code behaves like the trust mode.
  typedef enum logic [1:0] {
    MODE_TRUST = 2'd0,
    MODE_H264  = 2'd1,
    MODE_HEVC  = 2'd2,
    MODE_ALT   = 2'd3
  } codec_mode_t;

  // Parser phases: four length prefix bytes, header byte, body, stop.
  typedef enum logic [2:0] {
    PH_LEN0   = 3'd0,
    PH_LEN1   = 3'd1,
    PH_LEN2   = 3'd2,
    PH_LEN3   = 3'd3,
    PH_HEADER = 3'd4,
    PH_BODY   = 3'd5,
    PH_STOP   = 3'd6
  } parse_phase_t;

  localparam logic [4:0] H264_IDR_TYPE  = 5'd5;
  localparam logic [5:0] HEVC_IRAP_LOW  = 6'd16;
  localparam logic [5:0] HEVC_IRAP_HIGH = 6'd21;

  // True when the NAL header byte marks a random access picture.
  function automatic logic header_is_key(input codec_mode_t mode, input logic [7:0] hdr);
    logic [5:0] hevc_type;
    hevc_type = hdr[6:1];
    case (mode)
      MODE_H264: header_is_key = (hdr[4:0] == H264_IDR_TYPE);
      MODE_HEVC: header_is_key = hevc_type inside {[HEVC_IRAP_LOW:HEVC_IRAP_HIGH]};
      default:   header_is_key = 1'b0;
    endcase
  endfunction

endpackage

// ----- hdl/nal_keyframe_detector_unit.sv -----
// ----------------------------------------------------------------------------
// NAL keyframe detector
// Parses length-prefixed H.264 / HEVC packets byte by byte and reports, for
// each packet of the selected stream, whether it is a keyframe.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one packet byte per request, with in_last_byte
// set on the final byte and in_key_flag / in_stream_number describing the
// packet. Every byte request is parsed, whatever its stream. On the final
// byte of a packet whose stream number matches the selected stream, one
// result request is issued on the output channel; other packets give none.
// The result is registered and appears in the cycle after the final byte
// is taken. Throughput is one byte per cycle while in_ready is high; the
// parser updates its phase, a 24-bit length holding register and a 32-bit
// down counter once per byte, and a one-deep output register lets a new
// byte enter in the same cycle that a waiting result is taken.
// When the receiver stalls with a result pending, in_ready drops until that
// result is taken, so no result is ever overwritten.
// Reset (synchronous, active low) clears the parser to await a length byte,
// sets codec mode and selected stream to zero, the frame counter to zero and
// the last keyframe index to minus one, and empties the output register.
// Configuration writes take effect at the clock edge where cfg_we is high and
// are meant to be issued only while the block is idle.
// ----------------------------------------------------------------------------
module nal_keyframe_detector_unit #(
  parameter int FRAME_INDEX_BITS = nal_kf_pkg::FRAME_INDEX_BITS_DEF,
  parameter int STREAM_ID_BITS   = nal_kf_pkg::STREAM_ID_BITS_DEF
) (
  input  logic                                                     clk,
  input  logic                                                     rst_n,
  // Configuration write port.
  input  logic                                                     cfg_we,
  input  logic                                                     cfg_index,
  input  logic [((STREAM_ID_BITS > 2) ? STREAM_ID_BITS : 2)-1:0]   cfg_wdata,
  // Byte input channel.
  input  logic                                                     in_valid,
  output logic                                                     in_ready,
  input  logic [7:0]                                               in_data_byte,
  input  logic                                                     in_last_byte,
  input  logic                                                     in_key_flag,
  input  logic [STREAM_ID_BITS-1:0]                                in_stream_number,
  // Result channel.
  output logic                                                     out_valid,
  input  logic                                                     out_ready,
  output logic                                                     out_key_frame,
  output logic [FRAME_INDEX_BITS-1:0]                              out_frame_index,
  output logic signed [FRAME_INDEX_BITS:0]                         out_last_keyframe_index,
  output logic                                                     out_truncated
);
  import nal_kf_pkg::*;

  // Configuration registers.
  codec_mode_t               codec_mode_r;
  logic [STREAM_ID_BITS-1:0] sel_stream_r;

  // Parser state.
  parse_phase_t  phase_r, phase_nxt;
  logic [23:0]   len_acc_r, len_acc_nxt;
  logic [31:0]   remain_r, remain_nxt;
  logic          hdr_match_r, hdr_match_nxt;
  logic          kf_found_r, kf_found_nxt;

  // Counters for the packets of the selected stream.
  logic [FRAME_INDEX_BITS-1:0]     frame_cnt_r;
  logic signed [FRAME_INDEX_BITS:0] last_kf_r, last_kf_nxt;

  // Output register.
  logic                            out_valid_r;
  logic                            out_is_key_r;
  logic [FRAME_INDEX_BITS-1:0]     out_index_r;
  logic signed [FRAME_INDEX_BITS:0] out_last_kf_r;
  logic                            out_trunc_r;

  logic        accept;
  logic [31:0] full_len;
  logic [31:0] remain_dec;
  logic        nal_mode;
  logic        is_key;
  logic        trunc;
  logic        emit;

  // A byte can enter whenever the output register is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign full_len   = {len_acc_r, in_data_byte};
  assign remain_dec = remain_r - 32'd1;

  // Parser next state for one byte, before the end-of-packet clear.
  always_comb begin
    phase_nxt     = phase_r;
    len_acc_nxt   = len_acc_r;
    remain_nxt    = remain_r;
    hdr_match_nxt = hdr_match_r;
    kf_found_nxt  = kf_found_r;
    case (phase_r)
      PH_LEN0: begin
        len_acc_nxt = {len_acc_r[15:0], in_data_byte};
        phase_nxt   = PH_LEN1;
      end
      PH_LEN1: begin
        len_acc_nxt = {len_acc_r[15:0], in_data_byte};
        phase_nxt   = PH_LEN2;
      end
      PH_LEN2: begin
        len_acc_nxt = {len_acc_r[15:0], in_data_byte};
        phase_nxt   = PH_LEN3;
      end
      PH_LEN3: begin
        len_acc_nxt = '0;
        if (in_last_byte) begin
          phase_nxt = PH_STOP;
        end else if (full_len == 32'd0) begin
          // An empty NAL unit is skipped; the next byte opens a new prefix.
          phase_nxt = PH_LEN0;
        end else begin
          remain_nxt    = full_len;
          hdr_match_nxt = 1'b0;
          phase_nxt     = PH_HEADER;
        end
      end
      PH_HEADER, PH_BODY: begin
        if (phase_r == PH_HEADER) begin
          hdr_match_nxt = header_is_key(codec_mode_r, in_data_byte);
        end
        remain_nxt = remain_dec;
        if (remain_dec == 32'd0) begin
          if (hdr_match_nxt) begin
            kf_found_nxt = 1'b1;
            phase_nxt    = PH_STOP;
          end else begin
            phase_nxt = PH_LEN0;
          end
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      default: begin
        // Stop phase: the rest of the packet is ignored.
        phase_nxt = PH_STOP;
      end
    endcase
  end

  // End-of-packet decision.
  always_comb begin
    nal_mode = (codec_mode_r == MODE_H264) || (codec_mode_r == MODE_HEVC);
    if (nal_mode) begin
      is_key = in_key_flag && kf_found_nxt;
      trunc  = in_key_flag && ((phase_nxt == PH_HEADER) || (phase_nxt == PH_BODY)) &&
               (remain_nxt != 32'd0);
    end else begin
      is_key = in_key_flag;
      trunc  = 1'b0;
    end
    emit        = accept && in_last_byte && (in_stream_number == sel_stream_r);
    last_kf_nxt = is_key ? $signed({1'b0, frame_cnt_r}) : last_kf_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= MODE_TRUST;
      sel_stream_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CODEC_MODE) begin
        codec_mode_r <= codec_mode_t'(cfg_wdata[1:0]);
      end else begin
        sel_stream_r <= cfg_wdata[STREAM_ID_BITS-1:0];
      end
    end
  end

  // Parser registers; the parser restarts at every packet end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN0;
      len_acc_r   <= '0;
      remain_r    <= '0;
      hdr_match_r <= 1'b0;
      kf_found_r  <= 1'b0;
    end else if (accept) begin
      if (in_last_byte) begin
        phase_r     <= PH_LEN0;
        len_acc_r   <= '0;
        remain_r    <= '0;
        hdr_match_r <= 1'b0;
        kf_found_r  <= 1'b0;
      end else begin
        phase_r     <= phase_nxt;
        len_acc_r   <= len_acc_nxt;
        remain_r    <= remain_nxt;
        hdr_match_r <= hdr_match_nxt;
        kf_found_r  <= kf_found_nxt;
      end
    end
  end

  // Frame counter saturates at its maximum; the keyframe index follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= '0;
      last_kf_r   <= '1;
    end else if (emit) begin
      last_kf_r <= last_kf_nxt;
      if (frame_cnt_r != {FRAME_INDEX_BITS{1'b1}}) begin
        frame_cnt_r <= frame_cnt_r + FRAME_INDEX_BITS'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_is_key_r  <= is_key;
      out_index_r   <= frame_cnt_r;
      out_last_kf_r <= last_kf_nxt;
      out_trunc_r   <= trunc;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_key_frame           = out_is_key_r;
  assign out_frame_index         = out_index_r;
  assign out_last_keyframe_index = out_last_kf_r;
  assign out_truncated           = out_trunc_r;

endmodule
